// File: hdl/binary_face_list_deframer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the face list deframer
// Shared implication forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef BINARY_FACE_LIST_DEFRAMER_ASSERT_SVH
`define BINARY_FACE_LIST_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define BFLD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bfld check failed");

// Next-cycle implication, disabled while reset is asserted
`define BFLD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bfld check failed");

`endif

// File: hdl/bfld_pkg.sv
// ----------------------------------------------------------------------------
// bfld_pkg
// Types and constants shared by the face list deframer modules.
// ----------------------------------------------------------------------------
package bfld_pkg;

    // integer width codes
    localparam logic [1:0] WCODE_1B = 2'd0;
    localparam logic [1:0] WCODE_2B = 2'd1;
    localparam logic [1:0] WCODE_4B = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_COUNT_WIDTH = 2'd0;
    localparam logic [1:0] CFG_INDEX_WIDTH = 2'd1;
    localparam logic [1:0] CFG_BIG_ENDIAN  = 2'd2;
    localparam logic [1:0] CFG_FACE_TOTAL  = 2'd3;

    typedef struct packed {
        logic [1:0]  count_width_code;
        logic [1:0]  index_width_code;
        logic        big_endian;
        logic [31:0] face_total;
    } t_cfg;

    typedef struct packed {
        logic [31:0] value;
        logic        is_count;
        logic        face_end;
        logic        element_end;
    } t_result;

    // byte position of the final byte for a width code (code three acts as 4 bytes)
    function automatic logic [1:0] last_pos(input logic [1:0] code);
        logic [1:0] pos;
        case (code)
            WCODE_1B: pos = 2'd0;
            WCODE_2B: pos = 2'd1;
            default:  pos = 2'd3;
        endcase
        return pos;
    endfunction

endpackage

// File: hdl/bfld_core.sv
// ----------------------------------------------------------------------------
// bfld_core
// Integer assembly and face bookkeeping; one byte per step.
// ----------------------------------------------------------------------------
module bfld_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bfld_pkg::t_cfg   i_cfg,
    input  logic             i_ft_we,     // face_total write
    input  logic [31:0]      i_ft_data,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    output logic             o_res_valid,
    output bfld_pkg::t_result o_res
);
    import bfld_pkg::*;

    logic        r_reading;
    logic [1:0]  r_pos;
    logic [31:0] r_asm;
    logic [31:0] r_left;
    logic [31:0] r_faces;
    logic        r_finished;

    logic        n_reading;
    logic [1:0]  n_pos;
    logic [31:0] n_asm;
    logic [31:0] n_left;
    logic [31:0] n_faces;
    logic        n_finished;

    logic [31:0] asm_nxt;
    logic [31:0] faces_inc;
    logic        complete;
    logic        fend;
    logic        eend;
    logic        was_count;

    assign faces_inc = r_faces + 32'd1;
    assign complete  = r_pos >= last_pos(r_reading ? i_cfg.index_width_code
                                                   : i_cfg.count_width_code);
    assign asm_nxt   = i_cfg.big_endian ? {r_asm[23:0], i_byte}
                                        : (r_asm | ({24'd0, i_byte} << {r_pos, 3'b000}));
    assign was_count = !r_reading;
    assign fend      = was_count ? (asm_nxt == 32'd0) : (r_left == 32'd1);
    assign eend      = fend && (faces_inc >= i_cfg.face_total);

    always_comb begin
        n_reading  = r_reading;
        n_pos      = r_pos;
        n_asm      = r_asm;
        n_left     = r_left;
        n_faces    = r_faces;
        n_finished = r_finished;
        o_res_valid = 1'b0;
        if (i_ft_we) begin
            n_finished = r_faces >= i_ft_data;
        end else if (i_step && !r_finished) begin
            if (!complete) begin
                n_asm = asm_nxt;
                n_pos = r_pos + 2'd1;
            end else begin
                o_res_valid = 1'b1;
                n_asm = 32'd0;
                n_pos = 2'd0;
                if (was_count) begin
                    if (!fend) begin
                        n_reading = 1'b1;
                        n_left    = asm_nxt;
                    end
                end else begin
                    n_left = r_left - 32'd1;
                    if (fend) begin
                        n_reading = 1'b0;
                    end
                end
                if (fend) begin
                    n_faces    = faces_inc;
                    n_finished = eend;
                end
            end
        end
    end

    assign o_res.value       = asm_nxt;
    assign o_res.is_count    = was_count;
    assign o_res.face_end    = fend;
    assign o_res.element_end = eend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reading  <= 1'b0;
            r_pos      <= 2'd0;
            r_asm      <= 32'd0;
            r_left     <= 32'd0;
            r_faces    <= 32'd0;
            r_finished <= 1'b1;
        end else begin
            r_reading  <= n_reading;
            r_pos      <= n_pos;
            r_asm      <= n_asm;
            r_left     <= n_left;
            r_faces    <= n_faces;
            r_finished <= n_finished;
        end
    end

endmodule

// File: hdl/binary_face_list_deframer.sv
// ----------------------------------------------------------------------------
// binary_face_list_deframer
// Splits a binary mesh face block into face counts and vertex indices.
// ----------------------------------------------------------------------------
// One byte transaction is taken every clock unless the input stalls. A byte
// lands in an input register and passes through the assembler once the
// result slot is free; when it completes a count or an index, the value is
// loaded into the output register at the end of that cycle. The rate is set
// by the state update of the assembler (byte position, assembly word, indices
// left, faces done); it holds at one byte per clock while the output side
// keeps taking results. A stalled result only blocks the input when a byte is
// waiting behind it. Configuration writes are taken at any time (ready is
// always high) but should only be issued while idle. Once face_total faces
// have ended, further bytes are consumed silently.
// ----------------------------------------------------------------------------
module binary_face_list_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_value,
    output logic        o_is_count,
    output logic        o_face_end,
    output logic        o_element_end,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import bfld_pkg::*;

    t_cfg        r_cfg;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    t_result     r_out;

    logic        adv;       // output slot free, the input stage may move on
    logic        step;
    logic        cfg_we;
    logic        ft_we;
    logic        res_valid;
    t_result     res;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign ft_we       = cfg_we && (i_cfg_index == CFG_FACE_TOTAL);

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.count_width_code <= WCODE_1B;
            r_cfg.index_width_code <= WCODE_4B;
            r_cfg.big_endian       <= 1'b0;
            r_cfg.face_total       <= 32'd0;
        end else if (cfg_we) begin
            case (i_cfg_index)
                CFG_COUNT_WIDTH: r_cfg.count_width_code <= i_cfg_data[1:0];
                CFG_INDEX_WIDTH: r_cfg.index_width_code <= i_cfg_data[1:0];
                CFG_BIG_ENDIAN:  r_cfg.big_endian       <= i_cfg_data[0];
                CFG_FACE_TOTAL:  r_cfg.face_total       <= i_cfg_data;
                default:         r_cfg                  <= r_cfg;
            endcase
        end
    end

    // handshake: the byte stage advances whenever the result slot is free
    assign adv        = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && adv;
    assign o_in_stall = r_in_valid && !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_data_byte;
        end
    end

    bfld_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_ft_we     (ft_we),
        .i_ft_data   (i_cfg_data),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_value       = r_out.value;
    assign o_is_count    = r_out.is_count;
    assign o_face_end    = r_out.face_end;
    assign o_element_end = r_out.element_end;

endmodule

// File: hdl/bfld_checker.sv
// ----------------------------------------------------------------------------
// bfld_checker
// Port-level checks on the face list deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "binary_face_list_deframer_assert.svh"

module bfld_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_value,
    input logic        o_is_count,
    input logic        o_face_end,
    input logic        o_element_end
);

    // a held result keeps its value and face end flag
    `BFLD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_value) && $stable(o_face_end))

    // input only backs up behind a stalled result
    `BFLD_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)

    // the element can only end on a face boundary
    `BFLD_ASSERT_IMP(a_elem_face, i_clk, i_rst_n, o_out_valid && o_element_end, o_face_end)

    // a count ends its face exactly when it is zero
    `BFLD_ASSERT_IMP(a_count_end, i_clk, i_rst_n, o_out_valid && o_is_count, o_face_end == (o_value == 32'd0))

endmodule

bind binary_face_list_deframer bfld_checker u_bfld_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_value       (o_value),
    .o_is_count    (o_is_count),
    .o_face_end    (o_face_end),
    .o_element_end (o_element_end)
);

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the binary face list deframer. A directed table
// covers the corner cases, then random phases of face streams (random
// widths, byte order and face totals) run under random input gaps and
// output stalls. Results are scored against a behavioural copy of the
// deframer kept inside the bench, or against a directed row's own result.
// ----------------------------------------------------------------------------
module tb_top;
    import bfld_pkg::*;

    // width code three is not named in the package; it behaves as 4 bytes
    localparam logic [1:0] WCODE_RSVD = 2'd3;

    localparam int ITEMS_TARGET  = 1350; // bytes in the random part
    localparam int CALM_ITEMS    = 150;  // tail of the run without idling
    localparam int SETTLE_CYCLES = 4;    // input and result registers plus margin
    localparam int END_CYCLES    = 8;
    localparam int STALL_LIMIT   = 2000; // cycles with no transaction at all

    typedef enum logic {ROW_CFG, ROW_BYTE} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [1:0]  reg_idx;
        logic [31:0] data;    // register value, or the byte in [7:0]
        bit          typed;   // expected result written into the row
        t_result     result;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_data_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_value;
    logic        o_is_count;
    logic        o_face_end;
    logic        o_element_end;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    binary_face_list_deframer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_value       (o_value),
        .o_is_count    (o_is_count),
        .o_face_end    (o_face_end),
        .o_element_end (o_element_end),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Bench-side copy of the deframer state and its register file
    // ------------------------------------------------------------------
    t_cfg        cfg;
    bit          in_index;     // 1 once a non-zero count has been taken
    logic [1:0]  byte_pos;
    logic [31:0] acc_word;
    logic [31:0] idx_left;
    logic [31:0] faces_seen;
    bit          stream_done;  // element complete, bytes are swallowed

    t_result     pending_values [$];  // results still owed by the DUT
    logic [31:0] count_goal;          // count being encoded by the generator
    int          live_items;          // bytes taken in the random part
    int          mismatches;
    bit          calm;                // no idling on either side

    // Directed corner cases. Reset leaves face_total at zero, so the first
    // byte must vanish. Then: zero count, 4-byte extreme indices, element
    // end, swallowed byte, resume with a larger total, big endian 2-byte
    // count, 1-byte index, width code three.
    t_dir_row dir_rows [34] = '{
        '{ROW_BYTE, '0, 32'h0000_00AB, 1'b0, '0},
        '{ROW_CFG, CFG_FACE_TOTAL, 32'd3, 1'b0, '0},
        '{ROW_BYTE, '0, 32'h0000_0000, 1'b1, {32'h0000_0000, 1'b1, 1'b1, 1'b0}},
        '{ROW_BYTE, '0, 32'h0000_0002, 1'b1, {32'h0000_0002, 1'b1, 1'b0, 1'b0}},
        '{ROW_BYTE, '0, 32'h0000_00FF, 1'b0, '0},
        '{ROW_BYTE, '0, 32'h0000_00FF, 1'b0, '0},
        '{ROW_BYTE, '0, 32'h0000_00FF, 1'b0, '0},
        '{ROW_BYTE, '0, 32'h0000_00FF, 1'b1, {32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0}},
        '{ROW_BYTE, '0, 32'h0000_0000, 1'b0, '0},
        '{ROW_BYTE, '0, 32'h0000_0000, 1'b0, '0},
        '{ROW_BYTE, '0, 32'h0000_0000, 1'b0, '0},
        '{ROW_BYTE, '0, 32'h0000_0000, 1'b1, {32'h0000_0000, 1'b0, 1'b1, 1'b0}},
        '{ROW_BYTE, '0, 32'h0000_0001, 1'b1, {32'h0000_0001, 1'b1, 1'b0, 1'b0}},
        '{ROW_BYTE, '0, 32'h0000_0078, 1'b0, '0},
        '{ROW_BYTE, '0, 32'h0000_0056, 1'b0, '0},
        '{ROW_BYTE, '0, 32'h0000_0034, 1'b0, '0},
        '{ROW_BYTE, '0, 32'h0000_0012, 1'b1, {32'h1234_5678, 1'b0, 1'b1, 1'b1}},
        '{ROW_BYTE, '0, 32'h0000_005A, 1'b0, '0},
        '{ROW_CFG, CFG_COUNT_WIDTH, 32'(WCODE_2B), 1'b0, '0},
        '{ROW_CFG, CFG_INDEX_WIDTH, 32'(WCODE_1B), 1'b0, '0},
        '{ROW_CFG, CFG_BIG_ENDIAN, 32'd1, 1'b0, '0},
        '{ROW_CFG, CFG_FACE_TOTAL, 32'd5, 1'b0, '0},
        '{ROW_BYTE, '0, 32'h0000_0000, 1'b0, '0},
        '{ROW_BYTE, '0, 32'h0000_0001, 1'b1, {32'h0000_0001, 1'b1, 1'b0, 1'b0}},
        '{ROW_BYTE, '0, 32'h0000_0080, 1'b1, {32'h0000_0080, 1'b0, 1'b1, 1'b0}},
        '{ROW_BYTE, '0, 32'h0000_0000, 1'b0, '0},
        '{ROW_BYTE, '0, 32'h0000_0000, 1'b1, {32'h0000_0000, 1'b1, 1'b1, 1'b1}},
        '{ROW_CFG, CFG_COUNT_WIDTH, 32'(WCODE_RSVD), 1'b0, '0},
        '{ROW_CFG, CFG_FACE_TOTAL, 32'd6, 1'b0, '0},
        '{ROW_BYTE, '0, 32'h0000_0000, 1'b0, '0},
        '{ROW_BYTE, '0, 32'h0000_0000, 1'b0, '0},
        '{ROW_BYTE, '0, 32'h0000_0000, 1'b0, '0},
        '{ROW_BYTE, '0, 32'h0000_0001, 1'b1, {32'h0000_0001, 1'b1, 1'b0, 1'b0}},
        '{ROW_BYTE, '0, 32'h0000_00FF, 1'b1, {32'h0000_00FF, 1'b0, 1'b1, 1'b1}}
    };

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic int bytes_for(input logic [1:0] code);
        case (code)
            WCODE_1B: return 1;
            WCODE_2B: return 2;
            default:  return 4;
        endcase
    endfunction

    // Advance the bench copy by one taken byte; hit is set when a count or
    // an index completes.
    task automatic deframe_byte(input logic [7:0] b, output bit hit, output t_result r);
        int          w;
        logic [31:0] word;
        hit = 1'b0;
        r   = '0;
        if (stream_done) return;
        w = bytes_for(in_index ? cfg.index_width_code : cfg.count_width_code);
        // each byte lands according to the byte order in force now
        if (cfg.big_endian)
            acc_word = {acc_word[23:0], b};
        else
            acc_word = acc_word | (32'(b) << (8 * byte_pos));
        // a width shrunk mid-integer completes it on the next byte
        if (int'(byte_pos) + 1 < w) begin
            byte_pos = byte_pos + 2'd1;
            return;
        end
        word       = acc_word;
        acc_word   = '0;
        byte_pos   = '0;
        r.value    = word;
        r.is_count = !in_index;
        if (!in_index) begin
            if (word == 32'd0) begin
                r.face_end = 1'b1;   // empty face ends on its count
            end else begin
                in_index = 1'b1;
                idx_left = word;
            end
        end else begin
            idx_left = idx_left - 32'd1;
            if (idx_left == 32'd0) begin
                r.face_end = 1'b1;
                in_index   = 1'b0;
            end
        end
        if (r.face_end) begin
            faces_seen = faces_seen + 32'd1;
            if (faces_seen >= cfg.face_total) begin
                r.element_end = 1'b1;
                stream_done   = 1'b1;
            end
        end
        hit = 1'b1;
    endtask

    // Next byte of a well-formed stream: counts stay small and are encoded
    // in the current width and order; index bytes are free, extremes often.
    // Occasional noise only where a stray count cannot exceed one byte.
    function automatic logic [7:0] pick_byte();
        int w;
        int sh;
        if (in_index || (cfg.count_width_code == WCODE_1B && $urandom_range(0, 99) < 6)) begin
            case ($urandom_range(0, 7))
                0:       return 8'h00;
                1:       return 8'hFF;
                default: return 8'($urandom_range(0, 255));
            endcase
        end
        w = bytes_for(cfg.count_width_code);
        if (byte_pos == 2'd0)
            count_goal = ($urandom_range(0, 6) == 0) ? 32'd0 :
                         $urandom_range(1, ($urandom_range(0, 9) == 0) ? 12 : 4);
        sh = cfg.big_endian ? (w - 1 - int'(byte_pos)) : int'(byte_pos);
        return 8'(count_goal >> (8 * sh));
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input bit typed, input t_result typed_r,
                             input int gap_pct);
        bit      hit;
        t_result r;
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        // transaction taken at this edge
        live_items++;
        deframe_byte(b, hit, r);
        if (typed)
            pending_values.push_back(typed_r);
        else if (hit)
            pending_values.push_back(r);
    endtask

    // Leaves valid high so writes can follow back to back; the caller
    // drops it once the batch is done.
    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_COUNT_WIDTH: cfg.count_width_code = val[1:0];
            CFG_INDEX_WIDTH: cfg.index_width_code = val[1:0];
            CFG_BIG_ENDIAN:  cfg.big_endian       = val[0];
            CFG_FACE_TOTAL: begin
                cfg.face_total = val;
                stream_done    = (faces_seen >= val);  // larger total resumes
            end
        endcase
    endtask

    // Idle point: all owed results in, then room for bytes that complete
    // nothing but are still inside the pipe.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_values.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Result stalls: random bursts between free-running stretches
    // ------------------------------------------------------------------
    initial begin : out_stall_gen
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            i_out_stall <= 1'b0;
            if (calm) begin
                @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
                if (!calm && $urandom_range(0, 2) != 0) begin
                    i_out_stall <= 1'b1;
                    repeat ($urandom_range(1, 16)) @(posedge i_clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard: every result transaction against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_values.size() == 0) begin
                $error("result with none owed: value %h is_count %b", o_value, o_is_count);
                mismatches++;
            end else begin
                want = pending_values.pop_front();
                if (o_value !== want.value) begin
                    $error("value: expected %h, got %h", want.value, o_value);
                    mismatches++;
                end
                if (o_is_count !== want.is_count) begin
                    $error("is_count: expected %b, got %b", want.is_count, o_is_count);
                    mismatches++;
                end
                if (o_face_end !== want.face_end) begin
                    $error("face_end: expected %b, got %b", want.face_end, o_face_end);
                    mismatches++;
                end
                if (o_element_end !== want.element_end) begin
                    $error("element_end: expected %b, got %b", want.element_end,
                           o_element_end);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any transaction on any channel
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watchdog
        int quiet_cycles;
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        int          n_bytes;
        int          gap_pct;
        logic [31:0] total;
        logic [7:0]  b;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_data_byte <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_COUNT_WIDTH;
        i_cfg_data  <= '0;

        // state as it stands after reset
        cfg.count_width_code = WCODE_1B;
        cfg.index_width_code = WCODE_4B;
        cfg.big_endian       = 1'b0;
        cfg.face_total       = '0;
        in_index    = 1'b0;
        byte_pos    = '0;
        acc_word    = '0;
        idx_left    = '0;
        faces_seen  = '0;
        stream_done = 1'b1;   // face_total of zero
        count_goal  = '0;
        live_items  = 0;
        mismatches  = 0;
        calm        = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table; register writes only at idle points
        for (int i = 0; i < $size(dir_rows); i++) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                if (i == 0 || dir_rows[i - 1].kind == ROW_BYTE) settle();
                cfg_write(dir_rows[i].reg_idx, dir_rows[i].data);
                if (i == $size(dir_rows) - 1 || dir_rows[i + 1].kind != ROW_CFG)
                    i_cfg_valid <= 1'b0;
            end else begin
                send_byte(dir_rows[i].data[7:0], dir_rows[i].typed, dir_rows[i].result, 25);
            end
        end

        // random phases: reconfigure at idle, then a run of stream bytes that
        // usually stops mid-face and often mid-integer
        live_items = 0;
        while (live_items < ITEMS_TARGET) begin
            settle();
            // width and byte order move only where the count being built
            // cannot be corrupted; mid-index changes are fair game
            if (in_index || byte_pos == 2'd0) begin
                if ($urandom_range(0, 2) == 0) cfg_write(CFG_COUNT_WIDTH, $urandom_range(0, 3));
                if ($urandom_range(0, 2) == 0) cfg_write(CFG_INDEX_WIDTH, $urandom_range(0, 3));
                if ($urandom_range(0, 2) == 0) cfg_write(CFG_BIG_ENDIAN, $urandom_range(0, 1));
            end
            if (stream_done || $urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 15))
                    0:       total = 32'd0;
                    1:       total = 32'hFFFF_FFFF;
                    2:       total = faces_seen;   // closes the element at once
                    default: total = faces_seen + $urandom_range(1, 10);
                endcase
                cfg_write(CFG_FACE_TOTAL, total);
            end
            i_cfg_valid <= 1'b0;

            gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 20;
            n_bytes = $urandom_range(1, 60);
            for (int k = 0; k < n_bytes && live_items < ITEMS_TARGET; k++) begin
                calm = (live_items >= ITEMS_TARGET - CALM_ITEMS);
                b = stream_done ? 8'($urandom_range(0, 255)) : pick_byte();
                send_byte(b, 1'b0, '0, gap_pct);
            end
        end

        settle();
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_values.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/bfld_pkg.sv
hdl/bfld_core.sv
hdl/binary_face_list_deframer.sv
hdl/bfld_checker.sv
dv/tb_top.sv
